// ===== rtl/ctb_pkg.sv =====
// ctb_pkg: shared types and constants for the text console character buffer
// used by ctb_seq, text_console_char_buffer and the testbench; no dependencies
package ctb_pkg;

  // fixed field widths of the request and result ports
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int RROW_W     = 5;
  localparam int RCOL_W     = 7;
  localparam int OROW_W     = 5;
  localparam int OCOL_W     = 7;
  localparam int COLS_REG_W = 7;
  localparam int ROWS_REG_W = 6;

  // register map, indexed by paddr[2]
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  localparam logic [COLS_REG_W-1:0] COLS_RESET = 7'd80;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 6'd25;

  // special characters
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_PUT,
    ST_RDWAIT,
    ST_FILL,
    ST_SCROLL,
    ST_DRAIN,
    ST_BLANK
  } state_t;

endpackage

// ===== rtl/ctb_mem.sv =====
// ctb_mem: cell store, one write port and one read port, registered read data
// depends on nothing
module ctb_mem #(
  parameter int DEPTH  = 2560,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ctb_seq.sv =====
// ctb_seq: command sequencer, cursor and row walker driving the cell store
// depends on ctb_pkg
module ctb_seq #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 32,
  parameter int ROW_W    = 5,
  parameter int COL_W    = 7,
  parameter int NROW_W   = 6,
  parameter int NCOL_W   = 7,
  parameter int ADDR_W   = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ctb_pkg::CMD_W-1:0]  command,
  input  logic [ctb_pkg::CHAR_W-1:0] char_code,
  input  logic [ctb_pkg::RROW_W-1:0] read_row,
  input  logic [ctb_pkg::RCOL_W-1:0] read_col,
  input  logic [NCOL_W-1:0]          eff_cols,
  input  logic [NROW_W-1:0]          eff_rows,
  output logic                       busy,
  output logic                       done,
  output logic [ROW_W-1:0]           cur_row,
  output logic [NCOL_W-1:0]          cur_col,
  output logic [ctb_pkg::CHAR_W-1:0] cell_q,
  output logic                       scr,
  output logic                       mem_we,
  output logic [ADDR_W-1:0]          mem_waddr,
  output logic [ctb_pkg::CHAR_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [ADDR_W-1:0]          mem_raddr,
  input  logic [ctb_pkg::CHAR_W-1:0] mem_rdata
);

  ctb_pkg::state_t state, state_next;
  ctb_pkg::cmd_t   cmd_q;
  logic [ctb_pkg::CHAR_W-1:0] ch_q;
  logic [ctb_pkg::RROW_W-1:0] rr_q;
  logic [ctb_pkg::RCOL_W-1:0] rc_q;
  logic [ROW_W-1:0]           wk_row;
  logic [COL_W-1:0]           wk_col;
  logic                       put_pending;
  logic                       cp_we;
  logic [ADDR_W-1:0]          cp_addr;

  logic [ROW_W-1:0]  sat_row;
  logic [NCOL_W-1:0] sat_col;
  logic [ROW_W-1:0]  next_row;
  logic [ROW_W-1:0]  last_row;
  logic              is_nl;
  logic              is_bs;
  logic              at_limit;
  logic              wraps;
  logic              rd_in_range;
  logic              wk_col_last;
  logic              wk_row_last;
  int                lim_c;
  int                lim_r;
  ctb_pkg::state_t   scroll_entry;

  function automatic logic [ADDR_W-1:0] cell_addr(input int row, input int col);
    return ADDR_W'(row * MAX_COLS + col);
  endfunction

  // cursor saturation and decode helpers
  always_comb begin
    sat_row     = (int'(cur_row) >= int'(eff_rows)) ? ROW_W'(int'(eff_rows) - 1) : cur_row;
    sat_col     = (cur_col > eff_cols) ? eff_cols : cur_col;
    is_nl       = (ch_q == ctb_pkg::CH_NEWLINE);
    is_bs       = (ch_q == ctb_pkg::CH_BACKSPACE);
    at_limit    = (sat_col >= eff_cols);
    wraps       = (int'(sat_row) + 1 >= int'(eff_rows));
    last_row    = ROW_W'(int'(eff_rows) - 1);
    next_row    = wraps ? last_row : ROW_W'(int'(sat_row) + 1);
    rd_in_range = (int'(rr_q) < int'(eff_rows)) && (int'(rc_q) < int'(eff_cols));
    scroll_entry = (int'(eff_rows) > 1) ? ctb_pkg::ST_SCROLL : ctb_pkg::ST_BLANK;
    lim_c       = (state == ctb_pkg::ST_INIT) ? MAX_COLS : int'(eff_cols);
    case (state)
      ctb_pkg::ST_INIT:   lim_r = MAX_ROWS;
      ctb_pkg::ST_SCROLL: lim_r = int'(eff_rows) - 1;
      default:            lim_r = int'(eff_rows);
    endcase
    wk_col_last = (int'(wk_col) == lim_c - 1);
    wk_row_last = (int'(wk_row) == lim_r - 1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ctb_pkg::ST_INIT: begin
        if (wk_col_last && wk_row_last) state_next = ctb_pkg::ST_IDLE;
      end
      ctb_pkg::ST_IDLE: begin
        if (start) state_next = ctb_pkg::ST_DECODE;
      end
      ctb_pkg::ST_DECODE: begin
        case (cmd_q)
          ctb_pkg::CMD_PUT: begin
            if (is_nl) begin
              state_next = wraps ? scroll_entry : ctb_pkg::ST_IDLE;
            end else if (is_bs) begin
              state_next = ctb_pkg::ST_IDLE;
            end else if (at_limit && wraps) begin
              state_next = scroll_entry;
            end else begin
              state_next = ctb_pkg::ST_PUT;
            end
          end
          ctb_pkg::CMD_CLEAR: state_next = ctb_pkg::ST_FILL;
          ctb_pkg::CMD_READ:  state_next = rd_in_range ? ctb_pkg::ST_RDWAIT : ctb_pkg::ST_IDLE;
          default:            state_next = ctb_pkg::ST_IDLE;
        endcase
      end
      ctb_pkg::ST_PUT:    state_next = ctb_pkg::ST_IDLE;
      ctb_pkg::ST_RDWAIT: state_next = ctb_pkg::ST_IDLE;
      ctb_pkg::ST_FILL: begin
        if (wk_col_last && wk_row_last) state_next = ctb_pkg::ST_IDLE;
      end
      ctb_pkg::ST_SCROLL: begin
        if (wk_col_last && wk_row_last) state_next = ctb_pkg::ST_DRAIN;
      end
      ctb_pkg::ST_DRAIN:  state_next = ctb_pkg::ST_BLANK;
      ctb_pkg::ST_BLANK: begin
        if (wk_col_last) state_next = put_pending ? ctb_pkg::ST_PUT : ctb_pkg::ST_IDLE;
      end
      default: state_next = ctb_pkg::ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    busy      = (state != ctb_pkg::ST_IDLE);
    mem_we    = 1'b0;
    mem_waddr = cell_addr(int'(wk_row), int'(wk_col));
    mem_wdata = ctb_pkg::CH_SPACE;
    mem_re    = 1'b0;
    mem_raddr = cell_addr(int'(wk_row) + 1, int'(wk_col));
    case (state)
      ctb_pkg::ST_INIT, ctb_pkg::ST_FILL: begin
        mem_we = 1'b1;
      end
      ctb_pkg::ST_DECODE: begin
        if (cmd_q == ctb_pkg::CMD_PUT && is_nl == 1'b0 && is_bs && sat_col != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(int'(sat_row), int'(sat_col) - 1);
        end
        if (cmd_q == ctb_pkg::CMD_READ && rd_in_range) begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(int'(rr_q), int'(rc_q));
        end
      end
      ctb_pkg::ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(int'(cur_row), int'(cur_col));
        mem_wdata = ch_q;
      end
      ctb_pkg::ST_SCROLL, ctb_pkg::ST_DRAIN: begin
        mem_re    = (state == ctb_pkg::ST_SCROLL);
        mem_we    = cp_we;
        mem_waddr = cp_addr;
        mem_wdata = mem_rdata;
      end
      ctb_pkg::ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(int'(last_row), int'(wk_col));
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ctb_pkg::ST_INIT;
      wk_row      <= '0;
      wk_col      <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      done        <= 1'b0;
      cp_we       <= 1'b0;
      put_pending <= 1'b0;
      scr         <= 1'b0;
    end else begin
      state   <= state_next;
      done    <= (state_next == ctb_pkg::ST_IDLE) && (state != ctb_pkg::ST_IDLE)
                 && (state != ctb_pkg::ST_INIT);
      cp_we   <= (state == ctb_pkg::ST_SCROLL);
      cp_addr <= cell_addr(int'(wk_row), int'(wk_col));
      case (state)
        ctb_pkg::ST_INIT, ctb_pkg::ST_FILL, ctb_pkg::ST_SCROLL: begin
          if (wk_col_last) begin
            wk_col <= '0;
            wk_row <= ROW_W'(int'(wk_row) + 1);
          end else begin
            wk_col <= COL_W'(int'(wk_col) + 1);
          end
          if (state == ctb_pkg::ST_FILL && wk_col_last && wk_row_last) begin
            cur_row <= '0;
            cur_col <= '0;
          end
        end
        ctb_pkg::ST_IDLE: begin
          if (start) begin
            cmd_q       <= ctb_pkg::cmd_t'(command);
            ch_q        <= char_code;
            rr_q        <= read_row;
            rc_q        <= read_col;
            scr         <= 1'b0;
            cell_q      <= '0;
            put_pending <= 1'b0;
          end
        end
        ctb_pkg::ST_DECODE: begin
          wk_row <= '0;
          wk_col <= '0;
          if (cmd_q == ctb_pkg::CMD_PUT) begin
            put_pending <= !is_nl && !is_bs;
            if (is_nl || (!is_bs && at_limit)) begin
              cur_row <= next_row;
              cur_col <= '0;
              scr     <= wraps;
            end else if (is_bs) begin
              cur_row <= sat_row;
              cur_col <= (sat_col != '0) ? NCOL_W'(int'(sat_col) - 1) : sat_col;
            end else begin
              cur_row <= sat_row;
              cur_col <= sat_col;
            end
          end
        end
        ctb_pkg::ST_PUT: begin
          cur_col <= NCOL_W'(int'(cur_col) + 1);
        end
        ctb_pkg::ST_RDWAIT: begin
          cell_q <= mem_rdata;
        end
        ctb_pkg::ST_DRAIN: begin
          wk_col <= '0;
        end
        ctb_pkg::ST_BLANK: begin
          wk_col <= COL_W'(int'(wk_col) + 1);
        end
        default: begin
          wk_col <= wk_col;
        end
      endcase
    end
  end

endmodule

// ===== rtl/text_console_char_buffer.sv =====
// text_console_char_buffer: top level, register port, size limiting and checks
// depends on ctb_pkg, ctb_mem and ctb_seq
//
//  channel   handshake              payload
//  request   start, busy            command, char_code, read_row, read_col
//  result    done (one-cycle pulse) cursor_row_out, cursor_col_out, cell_char, scrolled
//  config    psel/penable/pwrite    paddr, pwdata, prdata, pready (always high)
//
// a put or in-range read passes decode and then the put or read-wait state; a newline without
// scroll, a backspace, an out-of-range read or the unused command leave from decode. a scroll
// copies (rows-1)*cols cells up, drains the last copy and blanks the last row's cols cells;
// clear fills rows*cols cells; both are set by the single write port of the cell memory.
// after reset the whole store is swept to spaces with busy high; config writes are taken
// at any time. done shows each result for exactly one cycle.
module text_console_char_buffer #(
  parameter int MAX_COLS = 80,
  parameter int MAX_ROWS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  // request side
  input  logic                       start,
  output logic                       busy,
  input  logic [ctb_pkg::CMD_W-1:0]  command,
  input  logic [ctb_pkg::CHAR_W-1:0] char_code,
  input  logic [ctb_pkg::RROW_W-1:0] read_row,
  input  logic [ctb_pkg::RCOL_W-1:0] read_col,
  // result side
  output logic                       done,
  output logic [ctb_pkg::OROW_W-1:0] cursor_row_out,
  output logic [ctb_pkg::OCOL_W-1:0] cursor_col_out,
  output logic [ctb_pkg::CHAR_W-1:0] cell_char,
  output logic                       scrolled,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // widths that follow from the grid size
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int NROW_W = $clog2(MAX_ROWS + 1);
  localparam int NCOL_W = $clog2(MAX_COLS + 1);
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ctb_pkg::COLS_REG_W-1:0] cols_in_use;
  logic [ctb_pkg::ROWS_REG_W-1:0] rows_in_use;
  logic [NCOL_W-1:0]              eff_cols;
  logic [NROW_W-1:0]              eff_rows;
  logic                           cfg_wr;

  logic [ROW_W-1:0]           cur_row;
  logic [NCOL_W-1:0]          cur_col;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic [ctb_pkg::CHAR_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [ADDR_W-1:0]          mem_raddr;
  logic [ctb_pkg::CHAR_W-1:0] mem_rdata;

  // register port: two registers, selected by paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use <= ctb_pkg::COLS_RESET;
      rows_in_use <= ctb_pkg::ROWS_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        ctb_pkg::REG_COLS: cols_in_use <= pwdata[ctb_pkg::COLS_REG_W-1:0];
        ctb_pkg::REG_ROWS: rows_in_use <= pwdata[ctb_pkg::ROWS_REG_W-1:0];
        default:           cols_in_use <= cols_in_use;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ctb_pkg::REG_COLS: prdata = 32'(cols_in_use);
      ctb_pkg::REG_ROWS: prdata = 32'(rows_in_use);
      default:           prdata = '0;
    endcase
  end

  // sizes in force: zero acts as one, anything above the grid as the grid
  always_comb begin
    if (cols_in_use == '0) begin
      eff_cols = NCOL_W'(1);
    end else if (int'(cols_in_use) > MAX_COLS) begin
      eff_cols = NCOL_W'(MAX_COLS);
    end else begin
      eff_cols = NCOL_W'(cols_in_use);
    end
    if (rows_in_use == '0) begin
      eff_rows = NROW_W'(1);
    end else if (int'(rows_in_use) > MAX_ROWS) begin
      eff_rows = NROW_W'(MAX_ROWS);
    end else begin
      eff_rows = NROW_W'(rows_in_use);
    end
  end

  ctb_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ctb_pkg::CHAR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ctb_seq #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .ROW_W    (ROW_W),
    .COL_W    (COL_W),
    .NROW_W   (NROW_W),
    .NCOL_W   (NCOL_W),
    .ADDR_W   (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .command   (command),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .eff_cols  (eff_cols),
    .eff_rows  (eff_rows),
    .busy      (busy),
    .done      (done),
    .cur_row   (cur_row),
    .cur_col   (cur_col),
    .cell_q    (cell_char),
    .scr       (scrolled),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // cursor as reported on the result ports
  assign cursor_row_out = ctb_pkg::OROW_W'(cur_row);
  assign cursor_col_out = ctb_pkg::OCOL_W'(cur_col);

  // a result is only ever shown while the sequencer can take a new request
  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // an accepted request always occupies the sequencer on the next cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request accepted but sequencer not busy");

  // a scroll always leaves the cursor on the last row in use
  a_scroll_row : assert property (@(posedge clk) disable iff (rst)
    (done && scrolled) |-> (int'(cur_row) == int'(eff_rows) - 1))
    else $error("scroll left cursor off the last row");

  // one strobe per request
  a_done_pulse : assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking test of text_console_char_buffer, with its own cell grid and cursor
// model, an apb register writer and a result checker; depends on ctb_pkg and the block's rtl
module testbench;

  localparam int GRID_COLS      = 80;
  localparam int GRID_ROWS      = 32;
  localparam int RANDOM_ITEMS   = 650;
  // longest silence: the sweep after reset, a full-size scroll or clear, then margin
  localparam int WATCHDOG_LIMIT = 20000;
  // a full-size scroll copies (rows-1)*cols cells, then drains and blanks cols cells
  localparam int SETTLE_CYCLES  = 3000;

  typedef struct packed {
    logic [ctb_pkg::OROW_W-1:0] row;
    logic [ctb_pkg::OCOL_W-1:0] col;
    logic [ctb_pkg::CHAR_W-1:0] cell_val;
    logic                       scrolled;
  } console_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side, all known from time zero
  logic                       start = 1'b0;
  logic                       busy;
  logic [ctb_pkg::CMD_W-1:0]  command = '0;
  logic [ctb_pkg::CHAR_W-1:0] char_code = '0;
  logic [ctb_pkg::RROW_W-1:0] read_row = '0;
  logic [ctb_pkg::RCOL_W-1:0] read_col = '0;

  // result side
  logic                       done;
  logic [ctb_pkg::OROW_W-1:0] cursor_row_out;
  logic [ctb_pkg::OCOL_W-1:0] cursor_col_out;
  logic [ctb_pkg::CHAR_W-1:0] cell_char;
  logic                       scrolled;

  // register port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // model of the block: grid, cursor and the two size registers
  logic [ctb_pkg::CHAR_W-1:0]     model_grid [GRID_ROWS][GRID_COLS];
  int                             cur_row;
  int                             cur_col;
  logic [ctb_pkg::COLS_REG_W-1:0] cols_reg;
  logic [ctb_pkg::ROWS_REG_W-1:0] rows_reg;

  console_result_t expected_results [$];
  int              mismatch_count = 0;
  int              idle_cycles = 0;
  bit              no_gaps = 1'b0;

  text_console_char_buffer #(
    .MAX_COLS (GRID_COLS),
    .MAX_ROWS (GRID_ROWS)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .char_code      (char_code),
    .read_row       (read_row),
    .read_col       (read_col),
    .done           (done),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cell_char      (cell_char),
    .scrolled       (scrolled),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // model
  // ---------------------------------------------------------------------------

  // a size of 0 behaves as 1, anything above the grid behaves as the grid size
  function automatic int active_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > GRID_COLS) return GRID_COLS;
    return cols_reg;
  endfunction

  function automatic int active_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > GRID_ROWS) return GRID_ROWS;
    return rows_reg;
  endfunction

  // cursor to the start of the next row; past the bottom the region moves up one
  // row and the last row is blanked, in which case 1 is returned
  function automatic bit line_feed(int rows, int cols);
    int r;
    int c;
    cur_col = 0;
    cur_row++;
    if (cur_row < rows) return 1'b0;
    for (r = 0; r + 1 < rows; r++)
      for (c = 0; c < cols; c++) model_grid[r][c] = model_grid[r+1][c];
    for (c = 0; c < cols; c++) model_grid[rows-1][c] = ctb_pkg::CH_SPACE;
    cur_row = rows - 1;
    return 1'b1;
  endfunction

  function automatic console_result_t console_step(ctb_pkg::cmd_t cmd,
                                                   logic [ctb_pkg::CHAR_W-1:0] ch,
                                                   logic [ctb_pkg::RROW_W-1:0] rr,
                                                   logic [ctb_pkg::RCOL_W-1:0] rc);
    int              cols;
    int              rows;
    int              r;
    int              c;
    console_result_t res;
    cols = active_cols();
    rows = active_rows();
    res  = '0;
    case (cmd)
      ctb_pkg::CMD_PUT: begin
        // a cursor left outside the region by a size change is pulled back first
        if (cur_row >= rows) cur_row = rows - 1;
        if (cur_col > cols) cur_col = cols;
        if (ch == ctb_pkg::CH_NEWLINE) begin
          res.scrolled = line_feed(rows, cols);
        end else if (ch == ctb_pkg::CH_BACKSPACE) begin
          // never crosses to the previous row
          if (cur_col > 0) begin
            cur_col--;
            model_grid[cur_row][cur_col] = ctb_pkg::CH_SPACE;
          end
        end else begin
          // at the column limit the character goes to the next row
          if (cur_col >= cols) res.scrolled = line_feed(rows, cols);
          model_grid[cur_row][cur_col] = ch;
          cur_col++;
        end
      end
      ctb_pkg::CMD_CLEAR: begin
        for (r = 0; r < rows; r++)
          for (c = 0; c < cols; c++) model_grid[r][c] = ctb_pkg::CH_SPACE;
        cur_row = 0;
        cur_col = 0;
      end
      ctb_pkg::CMD_READ: begin
        if (rr < rows && rc < cols) res.cell_val = model_grid[rr][rc];
      end
      default: ;
    endcase
    res.row = ctb_pkg::OROW_W'(cur_row);
    res.col = ctb_pkg::OCOL_W'(cur_col);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: outputs sampled at the falling edge, away from the drive edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    console_result_t exp_res;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no request waiting, row %0d col %0d cell %0d scrolled %0d",
                 $time, cursor_row_out, cursor_col_out, cell_char, scrolled);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (cursor_row_out !== exp_res.row) begin
          $display("%0t: cursor_row_out expected %0d got %0d",
                   $time, exp_res.row, cursor_row_out);
          mismatch_count++;
        end
        if (cursor_col_out !== exp_res.col) begin
          $display("%0t: cursor_col_out expected %0d got %0d",
                   $time, exp_res.col, cursor_col_out);
          mismatch_count++;
        end
        if (cell_char !== exp_res.cell_val) begin
          $display("%0t: cell_char expected %0d got %0d", $time, exp_res.cell_val, cell_char);
          mismatch_count++;
        end
        if (scrolled !== exp_res.scrolled) begin
          $display("%0t: scrolled expected %0d got %0d", $time, exp_res.scrolled, scrolled);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: any request taken, result shown or register access resets the count
  always @(negedge clk) begin
    if (rst || (start && !busy) || done || psel) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one, none at all in burst phases
  function automatic int pick_gap();
    int roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // called at a rising edge; returns at the edge that took the request, or after
  // the gap that follows it, with start left high only when no gap is wanted
  task automatic send_request(ctb_pkg::cmd_t cmd, logic [ctb_pkg::CHAR_W-1:0] ch,
                              logic [ctb_pkg::RROW_W-1:0] rr,
                              logic [ctb_pkg::RCOL_W-1:0] rc);
    int gap;
    start     <= 1'b1;
    command   <= cmd;
    char_code <= ch;
    read_row  <= rr;
    read_col  <= rc;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    expected_results.push_back(console_step(cmd, ch, rr, rc));
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // request with random filler in the fields that the command ignores
  task automatic send_plain(ctb_pkg::cmd_t cmd);
    send_request(cmd, ctb_pkg::CHAR_W'($urandom), ctb_pkg::RROW_W'($urandom),
                 ctb_pkg::RCOL_W'($urandom));
  endtask

  task automatic put_char(logic [ctb_pkg::CHAR_W-1:0] ch);
    send_request(ctb_pkg::CMD_PUT, ch, ctb_pkg::RROW_W'($urandom),
                 ctb_pkg::RCOL_W'($urandom));
  endtask

  task automatic read_cell(int rr, int rc);
    send_request(ctb_pkg::CMD_READ, ctb_pkg::CHAR_W'($urandom), ctb_pkg::RROW_W'(rr),
                 ctb_pkg::RCOL_W'(rc));
  endtask

  // stop sending and let every outstanding request finish
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------

  // setup then access phase; ends in the cycle after psel drops
  task automatic apb_access(bit wr, logic [2:0] addr, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    rdata = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // writes one size register with junk above its width, then reads it back
  task automatic set_register(logic idx, int value, int width);
    logic [31:0] wdata;
    logic [31:0] rdata;
    logic [31:0] want;
    wdata = ($urandom() << width) | value;
    want  = wdata & ((32'd1 << width) - 1);
    apb_access(1'b1, {idx, 2'b00}, wdata, rdata);
    if (idx == ctb_pkg::REG_COLS) cols_reg = ctb_pkg::COLS_REG_W'(want);
    else rows_reg = ctb_pkg::ROWS_REG_W'(want);
    apb_access(1'b0, {idx, 2'b00}, '0, rdata);
    if (rdata !== want) begin
      $display("%0t: register %0d read back expected %0d got %0d", $time, idx, want, rdata);
      mismatch_count++;
    end
  endtask

  task automatic set_sizes(int cols, int rows);
    set_register(ctb_pkg::REG_COLS, cols, ctb_pkg::COLS_REG_W);
    set_register(ctb_pkg::REG_ROWS, rows, ctb_pkg::ROWS_REG_W);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // grid after reset at the default 80 by 25, reads outside it, the unused command
  task automatic test_reset_contents();
    read_cell(0, 0);
    read_cell(25, 80);
    read_cell(31, 127);
    send_plain(ctb_pkg::CMD_NONE);
  endtask

  // extreme character codes, backspace, newline, backspace at the row start
  task automatic test_put_controls();
    put_char(8'd0);
    put_char(8'd255);
    put_char(ctb_pkg::CH_BACKSPACE);
    put_char(ctb_pkg::CH_NEWLINE);
    put_char(ctb_pkg::CH_BACKSPACE);
  endtask

  // 2 by 2 region: wrap at the column limit, wrap that scrolls, newline that scrolls
  task automatic test_wrap_and_scroll();
    wait_idle();
    set_sizes(2, 2);
    send_plain(ctb_pkg::CMD_CLEAR);
    put_char("a");
    put_char("b");
    put_char("c");
    put_char("d");
    put_char("e");
    put_char(ctb_pkg::CH_NEWLINE);
  endtask

  // zero sizes act as one, oversized registers act as the full grid
  task automatic test_size_limits();
    wait_idle();
    set_sizes(0, 0);
    // cursor is below the single row here, so the put pulls it back
    put_char("x");
    put_char("y");
    wait_idle();
    set_sizes(127, 63);
    read_cell(31, 79);
  endtask

  // shrink the region under the cursor without clearing it
  task automatic test_cursor_outside();
    put_char("p");
    put_char("q");
    put_char("r");
    wait_idle();
    set_sizes(2, 1);
    // reported as it stands, not pulled back
    send_plain(ctb_pkg::CMD_NONE);
    put_char("z");
  endtask

  // one random request shaped for the current region
  task automatic random_request();
    int roll;
    int cols;
    int rows;
    roll = $urandom_range(0, 99);
    cols = active_cols();
    rows = active_rows();
    if (roll < 55) begin
      put_char(ctb_pkg::CHAR_W'($urandom));
    end else if (roll < 67) begin
      put_char(ctb_pkg::CH_NEWLINE);
    end else if (roll < 75) begin
      put_char(ctb_pkg::CH_BACKSPACE);
    end else if (roll < 91) begin
      // mostly inside the region, sometimes anywhere the fields reach
      if ($urandom_range(0, 4) != 0) read_cell($urandom_range(0, rows - 1),
                                               $urandom_range(0, cols - 1));
      else read_cell($urandom_range(0, 31), $urandom_range(0, 127));
    end else if (roll < 94) begin
      send_plain(ctb_pkg::CMD_CLEAR);
    end else begin
      send_plain(ctb_pkg::CMD_NONE);
    end
  endtask

  // phases of random text, each with its own region size; mostly small regions
  // so that scrolls stay cheap, a few at the extremes
  task automatic test_random_text();
    int sent;
    int phase_items;
    int new_cols;
    int new_rows;
    int mode;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // every phase begins with the sender holding off until all results are in
      wait_idle();
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        case ($urandom_range(0, 3))
          0:       new_cols = 0;
          1:       new_cols = 1;
          2:       new_cols = GRID_COLS;
          default: new_cols = $urandom_range(GRID_COLS + 1, 127);
        endcase
        case ($urandom_range(0, 3))
          0:       new_rows = 0;
          1:       new_rows = 1;
          2:       new_rows = GRID_ROWS;
          default: new_rows = $urandom_range(GRID_ROWS + 1, 63);
        endcase
      end else if (mode == 1) begin
        new_cols = $urandom_range(1, GRID_COLS);
        new_rows = $urandom_range(1, GRID_ROWS);
      end else begin
        new_cols = $urandom_range(1, 10);
        new_rows = $urandom_range(1, 5);
      end
      set_sizes(new_cols, new_rows);
      no_gaps = ($urandom_range(0, 3) == 0);
      // usually cleared after a resize, sometimes left to leave the cursor outside
      if ($urandom_range(0, 3) != 0) begin
        send_plain(ctb_pkg::CMD_CLEAR);
        sent++;
      end
      if (active_cols() * active_rows() > 256) phase_items = $urandom_range(15, 25);
      else phase_items = $urandom_range(30, 70);
      repeat (phase_items) begin
        random_request();
        sent++;
        if ($urandom_range(0, 99) == 0) wait_idle();
      end
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    int c;
    // model state after reset
    for (r = 0; r < GRID_ROWS; r++)
      for (c = 0; c < GRID_COLS; c++) model_grid[r][c] = ctb_pkg::CH_SPACE;
    cur_row  = 0;
    cur_col  = 0;
    cols_reg = ctb_pkg::COLS_RESET;
    rows_reg = ctb_pkg::ROWS_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // the block sweeps its store after reset with busy high; the sender waits on busy
    test_reset_contents();
    test_put_controls();
    test_wrap_and_scroll();
    test_size_limits();
    test_cursor_outside();
    test_random_text();

    wait_idle();
    // long enough for any stray result to show
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== text_console_char_buffer.f =====
rtl/ctb_pkg.sv
rtl/ctb_mem.sv
rtl/ctb_seq.sv
rtl/text_console_char_buffer.sv
test/testbench.sv
